/* sv/tamb_pkg.sv */
// Package: shared types, constants, CORDIC angle table and a rounding Q30 multiply for the matrix builder.
package tamb_pkg;
   localparam int CordicSteps = 30;
   localparam logic signed [35:0] AngPi     = 36'sd3373259426;
   localparam logic signed [35:0] AngHalfPi = 36'sd1686629713;
   localparam logic signed [35:0] AngTwoPi  = 36'sd6746518852;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   typedef logic signed [33:0] q30_type;
   typedef logic signed [35:0] ang_type;

   typedef struct packed {
      q30_type x;
      q30_type y;
      ang_type z;
      logic    flip;
   } cordic_type;

   function automatic ang_type atan_q30(input int i);
      ang_type r;
      case (i)
         0: r = 36'sd843314856;
         1: r = 36'sd497837829;
         2: r = 36'sd263043836;
         3: r = 36'sd133525158;
         4: r = 36'sd67021686;
         5: r = 36'sd33543515;
         6: r = 36'sd16775850;
         7: r = 36'sd8388437;
         8: r = 36'sd4194282;
         9: r = 36'sd2097149;
         default: r = (36'sd1 <<< (30 - i)) - 36'sd1;
      endcase
      return r;
   endfunction

   function automatic logic signed [33:0] mul30(input q30_type a, input q30_type b);
      logic signed [67:0] p;
      p = a * b + (68'sd1 <<< 29);
      return 34'(p >>> 30);
   endfunction
endpackage

/* sv/tamb_cordic.sv */
// Pipelined rotation-mode CORDIC: angle reduction then one step per stage.
module tamb_cordic (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [15:0] angle,
   output logic out_valid,
   output tamb_pkg::q30_type sin_q,
   output tamb_pkg::q30_type cos_q
);
   import tamb_pkg::*;

   cordic_type stage_ff [0:CordicSteps];
   cordic_type stage_in [0:CordicSteps];
   logic [CordicSteps:0] valid_ff;

   always_comb begin
      ang_type th;
      logic fl;
      th = ang_type'(angle) <<< 18;
      fl = 1'b0;
      if (th > AngPi) th = th - AngTwoPi;
      else if (th < -AngPi) th = th + AngTwoPi;
      if (th > AngHalfPi) begin
         th = th - AngPi;
         fl = 1'b1;
      end else if (th < -AngHalfPi) begin
         th = th + AngPi;
         fl = 1'b1;
      end
      stage_in[0] = '{x: CordicGain, y: '0, z: th, flip: fl};
      for (int i = 0; i < CordicSteps; i++) begin
         stage_in[i+1] = stage_ff[i];
         if (stage_ff[i].z >= 0) begin
            stage_in[i+1].x = stage_ff[i].x - (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y + (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z - atan_q30(i);
         end else begin
            stage_in[i+1].x = stage_ff[i].x + (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y - (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z + atan_q30(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[CordicSteps-1:0], in_valid};
      for (int i = 0; i <= CordicSteps; i++) stage_ff[i] <= stage_in[i];
   end

   assign out_valid = valid_ff[CordicSteps];
   assign sin_q = stage_ff[CordicSteps].flip ? -stage_ff[CordicSteps].y
                                             : stage_ff[CordicSteps].y;
   assign cos_q = stage_ff[CordicSteps].flip ? -stage_ff[CordicSteps].x
                                             : stage_ff[CordicSteps].x;
endmodule

/* sv/trs_affine_matrix_builder_core.sv */
// Top level: three CORDIC pipes, product stages, scaling and saturation.
// An accepted request passes the CORDIC pipes and stages 1 to 4 before its rsp_valid strobe.
// Throughput: one request per cycle; busy is always low (31 CORDIC stages set most of the depth).
// Requests with needs_update clear travel as bubbles and give no strobe.
// Reset: synchronous, clears every valid bit; the receiver cannot stall.
module trs_affine_matrix_builder_core #(
   parameter int MATRIX_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [31:0] req_position_x,
   input  logic signed [31:0] req_position_y,
   input  logic signed [31:0] req_position_z,
   input  logic signed [15:0] req_angle_x,
   input  logic signed [15:0] req_angle_y,
   input  logic signed [15:0] req_angle_z,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [15:0] req_scale_z,
   input  logic req_needs_update,
   output logic rsp_valid,
   output logic signed [31:0] rsp_m00, rsp_m01, rsp_m02, rsp_m03,
   output logic signed [31:0] rsp_m10, rsp_m11, rsp_m12, rsp_m13,
   output logic signed [31:0] rsp_m20, rsp_m21, rsp_m22, rsp_m23
);
   import tamb_pkg::*;

   localparam int Depth = CordicSteps + 1;
   localparam int Sh = 38 - MATRIX_FRAC_BITS;

   logic go;
   logic va, vb, vc;
   q30_type sa, ca, sb, cb, sc, cc;
   logic signed [31:0] pos_ff [0:Depth+2][0:2];
   logic signed [15:0] scl_ff [0:Depth+1][0:2];

   assign busy = 1'b0;
   assign go = start & req_needs_update;

   tamb_cordic u_cx (.clock, .reset, .in_valid(go), .angle(req_angle_x),
      .out_valid(va), .sin_q(sa), .cos_q(ca));
   tamb_cordic u_cy (.clock, .reset, .in_valid(go), .angle(req_angle_y),
      .out_valid(vb), .sin_q(sb), .cos_q(cb));
   tamb_cordic u_cz (.clock, .reset, .in_valid(go), .angle(req_angle_z),
      .out_valid(vc), .sin_q(sc), .cos_q(cc));

   always_ff @(posedge clock) begin
      pos_ff[0][0] <= req_position_x;
      pos_ff[0][1] <= req_position_y;
      pos_ff[0][2] <= req_position_z;
      scl_ff[0][0] <= req_scale_x;
      scl_ff[0][1] <= req_scale_y;
      scl_ff[0][2] <= req_scale_z;
      for (int i = 1; i <= Depth + 2; i++) pos_ff[i] <= pos_ff[i-1];
      for (int i = 1; i <= Depth + 1; i++) scl_ff[i] <= scl_ff[i-1];
   end

   // stage 1: first-level products
   q30_type sb1_ff, cc1_ff, sc1_ff, cb1_ff;
   q30_type p00_ff, p01_ff, sab_ff, cab_ff, ca_sc_ff, ca_cc_ff, sa_sc_ff, sa_cc_ff;
   q30_type p12_ff, p22_ff;
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; vo_ff <= 1'b0;
      end else begin
         v1_ff <= va & vb & vc; v2_ff <= v1_ff; v3_ff <= v2_ff; vo_ff <= v3_ff;
      end
      p00_ff <= mul30(cb, cc);
      p01_ff <= -mul30(cb, sc);
      sab_ff <= mul30(sa, sb);
      cab_ff <= mul30(ca, sb);
      ca_sc_ff <= mul30(ca, sc);
      ca_cc_ff <= mul30(ca, cc);
      sa_sc_ff <= mul30(sa, sc);
      sa_cc_ff <= mul30(sa, cc);
      p12_ff <= -mul30(sa, cb);
      p22_ff <= mul30(ca, cb);
      sb1_ff <= sb; cc1_ff <= cc; sc1_ff <= sc; cb1_ff <= cb;
   end

   // stage 2: rotation entries
   q30_type r_ff [0:2][0:2];
   always_ff @(posedge clock) begin
      r_ff[0][0] <= p00_ff;
      r_ff[0][1] <= p01_ff;
      r_ff[0][2] <= sb1_ff;
      r_ff[1][0] <= mul30(sab_ff, cc1_ff) + ca_sc_ff;
      r_ff[1][1] <= -mul30(sab_ff, sc1_ff) + ca_cc_ff;
      r_ff[1][2] <= p12_ff;
      r_ff[2][0] <= -mul30(cab_ff, cc1_ff) + sa_sc_ff;
      r_ff[2][1] <= mul30(cab_ff, sc1_ff) + sa_cc_ff;
      r_ff[2][2] <= p22_ff;
   end

   // stage 3: scale products; stage 4: round and saturate
   logic signed [51:0] k_ff [0:2][0:2];
   logic signed [31:0] m_ff [0:2][0:3];
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            k_ff[r][c] <= 52'(r_ff[r][c]) * 52'(scl_ff[Depth+1][c]);
   end

   function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
      if (v > 53'sd2147483647) return 32'sh7fffffff;
      if (v < -53'sd2147483648) return 32'sh80000000;
      return 32'(v);
   endfunction

   function automatic logic signed [31:0] trans(input logic signed [31:0] p);
      logic signed [52:0] e;
      e = 53'(p);
      if (MATRIX_FRAC_BITS >= 16) return sat32(e <<< (MATRIX_FRAC_BITS - 16));
      return sat32((e + (53'sd1 <<< (15 - MATRIX_FRAC_BITS))) >>> (16 - MATRIX_FRAC_BITS));
   endfunction

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++)
            m_ff[r][c] <= sat32((53'(k_ff[r][c]) + (53'sd1 <<< (Sh - 1))) >>> Sh);
         m_ff[r][3] <= trans(pos_ff[Depth+2][r]);
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_m00 = m_ff[0][0]; assign rsp_m01 = m_ff[0][1];
   assign rsp_m02 = m_ff[0][2]; assign rsp_m03 = m_ff[0][3];
   assign rsp_m10 = m_ff[1][0]; assign rsp_m11 = m_ff[1][1];
   assign rsp_m12 = m_ff[1][2]; assign rsp_m13 = m_ff[1][3];
   assign rsp_m20 = m_ff[2][0]; assign rsp_m21 = m_ff[2][1];
   assign rsp_m22 = m_ff[2][2]; assign rsp_m23 = m_ff[2][3];

`ifndef NO_ASSERTIONS
   a_cordic_lock: assert property (@(posedge clock) disable iff (reset)
      (va == vb) && (vb == vc)) else $error("CORDIC pipes out of step");
   a_stage_chain: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff) else $error("valid lost between stages");
   a_out_chain: assert property (@(posedge clock) disable iff (reset)
      v3_ff |=> rsp_valid) else $error("result strobe lost");
`endif
endmodule
